// ----- rtl/core/rftu_pkg.sv -----
// Shared types, constants and calendar functions of the RTC to Unix time converter.
package rftu_pkg;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 104;
  localparam int SECS_W     = 38;
  localparam int ACC_W      = 64;
  localparam int MULT_W     = 30;

  localparam logic        REG_HOUR_24_MODE = 1'b0;
  localparam logic        REG_BINARY_MODE  = 1'b1;

  localparam logic [7:0]  PM_FLAG_MASK     = 8'h7F;
  localparam logic [14:0] EPOCH_YEAR       = 15'd1970;
  localparam logic [6:0]  EPOCH_CENTURY    = 7'd19;
  localparam logic [6:0]  EPOCH_YEAR_IN_C  = 7'd70;
  localparam logic [MULT_W-1:0] SECS_PER_DAY  = 30'd86400;
  localparam logic [MULT_W-1:0] SECS_PER_HOUR = 30'd3600;
  localparam logic [MULT_W-1:0] SECS_PER_MIN  = 30'd60;
  localparam logic [MULT_W-1:0] NANOS_PER_SEC = 30'd1000000000;

  typedef enum logic [2:0] {
    MAC_NOP,
    MAC_CLR,
    MAC_LOAD,
    MAC_LOADC,
    MAC_STEP,
    MAC_ADD
  } mac_op_t;

  typedef struct packed {
    mac_op_t           op;
    logic [ACC_W-1:0]  a;
    logic [MULT_W-1:0] b;
  } mac_cmd_t;

  typedef struct packed {
    logic [6:0] cen;
    logic [6:0] yr;
    logic [3:0] mon;
    logic [4:0] day;
    logic [4:0] hr;
    logic [5:0] min;
    logic [5:0] sec;
    logic       leap;
    logic       bad;
  } dec_t;

  typedef struct packed {
    logic              done;
    logic              err;
    logic [SECS_W-1:0] secs;
    logic [ACC_W-1:0]  nanos;
  } res_t;

  function automatic logic [7:0] bcd_decode(input logic [7:0] b);
    return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
  endfunction

  function automatic logic leap_of(input logic [6:0] cen, input logic [6:0] yr);
    if (yr == 7'd0) begin
      return cen[1:0] == 2'b00;
    end
    return yr[1:0] == 2'b00;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    case (m)
      4'd2:    return 5'd28;
      4'd4:    return 5'd30;
      4'd6:    return 5'd30;
      4'd9:    return 5'd30;
      4'd11:   return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m);
    case (m)
      4'd2:    return 9'd31;
      4'd3:    return 9'd59;
      4'd4:    return 9'd90;
      4'd5:    return 9'd120;
      4'd6:    return 9'd151;
      4'd7:    return 9'd181;
      4'd8:    return 9'd212;
      4'd9:    return 9'd243;
      4'd10:   return 9'd273;
      4'd11:   return 9'd304;
      4'd12:   return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

endpackage

// ----- rtl/core/rtc_fields_to_unix_time.sv -----
// Top level of the converter from raw real-time-clock fields to Unix seconds and nanoseconds.
//
//   Channel  Direction  Contents
//   in_*     slave      tdata: raw century, year, month, day, hour, minute, second
//   out_*    master     tdata: unix seconds, unix nanoseconds; tuser: date error
//   cfg_*    write      index 0 hour_24_mode, index 1 binary_mode
//
// The run time of a valid date is set by the year walk and the shift-and-add products
// on the one shared accumulator; an invalid one goes from the check straight to done.
// One transaction is in work at a time; in_tready is high while the sequencer is idle.
// A finished result waits in the output register, and the sequencer holds it back
// while that register is full. Reset is synchronous and active low.
module rtc_fields_to_unix_time import rftu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // raw_century, raw_year, raw_month, raw_day, raw_hour, raw_minute, raw_second
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // unix_seconds, unix_nanoseconds, two zero bits
  output logic [OUT_DATA_W-1:0] out_tdata,
  // date_error
  output logic [0:0]            out_tuser,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic                  cfg_wdata
);

  logic                  hour_24_mode_r;
  logic                  binary_mode_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_err_r;
  logic                  accept;
  logic                  out_free;
  logic                  idle;
  logic [ACC_W-1:0]      acc;
  logic                  k_zero;
  dec_t                  dec;
  mac_cmd_t              cmd;
  res_t                  res;

  assign in_tready = idle;
  assign accept    = in_tvalid && idle;
  assign out_free  = !out_valid_r || out_tready;

  rftu_decode u_decode (
    .clk          (clk),
    .load         (accept),
    .hour_24_mode (hour_24_mode_r),
    .binary_mode  (binary_mode_r),
    .raw          (in_tdata),
    .dec          (dec)
  );

  rftu_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .out_free (out_free),
    .dec      (dec),
    .acc      (acc),
    .k_zero   (k_zero),
    .cmd      (cmd),
    .idle     (idle),
    .res      (res)
  );

  rftu_mac u_mac (
    .clk    (clk),
    .cmd    (cmd),
    .acc    (acc),
    .k_zero (k_zero)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_24_mode_r <= 1'b1;
      binary_mode_r  <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_HOUR_24_MODE) begin
        hour_24_mode_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_BINARY_MODE) begin
        binary_mode_r <= cfg_wdata;
      end
      if (res.done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (res.done) begin
      out_data_r <= {2'b00, res.nanos, res.secs};
      out_err_r  <= res.err;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_err_r;

endmodule

// ----- rtl/core/rftu_decode.sv -----
// Field decoder and range checker that registers one decoded date snapshot.
module rftu_decode import rftu_pkg::*; (
  input  logic                 clk,
  input  logic                 load,
  input  logic                 hour_24_mode,
  input  logic                 binary_mode,
  input  logic [IN_DATA_W-1:0] raw,
  output dec_t                 dec
);

  dec_t        dec_r;
  dec_t        dec_nxt;
  logic [7:0]  cen_v;
  logic [7:0]  yr_v;
  logic [7:0]  mon_v;
  logic [7:0]  day_v;
  logic [7:0]  hr_in;
  logic [7:0]  hr_v;
  logic [7:0]  min_v;
  logic [7:0]  sec_v;
  logic        pm;
  logic        leap;
  logic        bad;
  logic [14:0] year;
  logic [5:0]  mlen;
  logic [4:0]  hr24;

  always_comb begin
    pm    = !hour_24_mode && raw[39];
    hr_in = hour_24_mode ? raw[39:32] : (raw[39:32] & PM_FLAG_MASK);
    cen_v = binary_mode ? raw[7:0]   : bcd_decode(raw[7:0]);
    yr_v  = binary_mode ? raw[15:8]  : bcd_decode(raw[15:8]);
    mon_v = binary_mode ? raw[23:16] : bcd_decode(raw[23:16]);
    day_v = binary_mode ? raw[31:24] : bcd_decode(raw[31:24]);
    hr_v  = binary_mode ? hr_in      : bcd_decode(hr_in);
    min_v = binary_mode ? raw[47:40] : bcd_decode(raw[47:40]);
    sec_v = binary_mode ? raw[55:48] : bcd_decode(raw[55:48]);

    bad  = 1'b0;
    hr24 = hr_v[4:0];
    if (hour_24_mode) begin
      if (hr_v > 8'd23) begin
        bad = 1'b1;
      end
    end else begin
      if (hr_v < 8'd1 || hr_v > 8'd12) begin
        bad = 1'b1;
      end else if (hr_v == 8'd12) begin
        hr24 = pm ? 5'd12 : 5'd0;
      end else if (pm) begin
        hr24 = hr_v[4:0] + 5'd12;
      end
    end
    if (cen_v > 8'd99 || yr_v > 8'd99 || min_v > 8'd59 || sec_v > 8'd59) begin
      bad = 1'b1;
    end
    year = 15'({cen_v, 6'b0} + {1'b0, cen_v, 5'b0} + {4'b0, cen_v, 2'b0}) + {7'b0, yr_v};
    if (year < EPOCH_YEAR) begin
      bad = 1'b1;
    end
    leap = leap_of(cen_v[6:0], yr_v[6:0]);
    mlen = {1'b0, month_len(mon_v[3:0])};
    if (mon_v == 8'd2 && leap) begin
      mlen = mlen + 6'd1;
    end
    if (mon_v < 8'd1 || mon_v > 8'd12) begin
      bad = 1'b1;
    end else if (day_v < 8'd1 || day_v > {2'b00, mlen}) begin
      bad = 1'b1;
    end

    dec_nxt.cen  = cen_v[6:0];
    dec_nxt.yr   = yr_v[6:0];
    dec_nxt.mon  = mon_v[3:0];
    dec_nxt.day  = day_v[4:0];
    dec_nxt.hr   = hr24;
    dec_nxt.min  = min_v[5:0];
    dec_nxt.sec  = sec_v[5:0];
    dec_nxt.leap = leap;
    dec_nxt.bad  = bad;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dec_r <= dec_nxt;
    end
  end

  assign dec = dec_r;

endmodule

// ----- rtl/core/rftu_mac.sv -----
// Shared accumulator with one adder, used for day counting and shift-and-add products.
module rftu_mac import rftu_pkg::*; (
  input  logic             clk,
  input  mac_cmd_t         cmd,
  output logic [ACC_W-1:0] acc,
  output logic             k_zero
);

  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  acc_nxt;
  logic [ACC_W-1:0]  m_r;
  logic [ACC_W-1:0]  m_nxt;
  logic [MULT_W-1:0] k_r;
  logic [MULT_W-1:0] k_nxt;
  logic [ACC_W-1:0]  addend;
  logic [ACC_W-1:0]  sum;

  always_comb begin
    addend  = (cmd.op == MAC_ADD) ? cmd.a : (k_r[0] ? m_r : '0);
    sum     = acc_r + addend;
    acc_nxt = acc_r;
    m_nxt   = m_r;
    k_nxt   = k_r;
    case (cmd.op)
      MAC_CLR: begin
        acc_nxt = '0;
      end
      MAC_LOAD: begin
        m_nxt = cmd.a;
        k_nxt = cmd.b;
      end
      MAC_LOADC: begin
        m_nxt   = cmd.a;
        k_nxt   = cmd.b;
        acc_nxt = '0;
      end
      MAC_STEP: begin
        acc_nxt = sum;
        m_nxt   = {m_r[ACC_W-2:0], 1'b0};
        k_nxt   = {1'b0, k_r[MULT_W-1:1]};
      end
      MAC_ADD: begin
        acc_nxt = sum;
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    m_r   <= m_nxt;
    k_r   <= k_nxt;
  end

  assign acc    = acc_r;
  assign k_zero = (k_r == '0);

endmodule

// ----- rtl/core/rftu_seq.sv -----
// Sequencer that walks the years since the epoch and drives the shared accumulator.
module rftu_seq import rftu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             out_free,
  input  dec_t             dec,
  input  logic [ACC_W-1:0] acc,
  input  logic             k_zero,
  output mac_cmd_t         cmd,
  output logic             idle,
  output res_t             res
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_CHECK   = 11'b00000000010,
    S_YEARS   = 11'b00000000100,
    S_MONTH   = 11'b00000001000,
    S_LD_DAY  = 11'b00000010000,
    S_MUL_DAY = 11'b00000100000,
    S_MUL_HR  = 11'b00001000000,
    S_MUL_MIN = 11'b00010000000,
    S_SECS    = 11'b00100000000,
    S_MUL_NS  = 11'b01000000000,
    S_DONE    = 11'b10000000000
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  logic [6:0]        cc_r;
  logic [6:0]        cc_nxt;
  logic [6:0]        cy_r;
  logic [6:0]        cy_nxt;
  logic              err_r;
  logic              err_nxt;
  logic [SECS_W-1:0] secs_r;
  logic [SECS_W-1:0] secs_nxt;
  logic [9:0]        month_add;

  always_comb begin
    state_nxt = state_r;
    cc_nxt    = cc_r;
    cy_nxt    = cy_r;
    err_nxt   = err_r;
    secs_nxt  = secs_r;
    cmd.op    = MAC_NOP;
    cmd.a     = '0;
    cmd.b     = '0;
    month_add = {1'b0, days_before(dec.mon)} + {9'b0, (dec.mon > 4'd2) && dec.leap}
              + {5'b0, dec.day} - 10'd1;
    res.done  = 1'b0;
    res.err   = err_r;
    res.secs  = err_r ? '0 : secs_r;
    res.nanos = err_r ? '0 : acc;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        err_nxt = dec.bad;
        cc_nxt  = EPOCH_CENTURY;
        cy_nxt  = EPOCH_YEAR_IN_C;
        cmd.op  = MAC_CLR;
        state_nxt = dec.bad ? S_DONE : S_YEARS;
      end
      S_YEARS: begin
        if (cc_r == dec.cen && cy_r == dec.yr) begin
          state_nxt = S_MONTH;
        end else begin
          cmd.op = MAC_ADD;
          cmd.a  = ACC_W'(10'd365 + {9'b0, leap_of(cc_r, cy_r)});
          if (cy_r == 7'd99) begin
            cy_nxt = 7'd0;
            cc_nxt = cc_r + 7'd1;
          end else begin
            cy_nxt = cy_r + 7'd1;
          end
        end
      end
      S_MONTH: begin
        cmd.op    = MAC_ADD;
        cmd.a     = ACC_W'(month_add);
        state_nxt = S_LD_DAY;
      end
      S_LD_DAY: begin
        cmd.op    = MAC_LOADC;
        cmd.a     = acc;
        cmd.b     = SECS_PER_DAY;
        state_nxt = S_MUL_DAY;
      end
      S_MUL_DAY: begin
        if (k_zero) begin
          cmd.op    = MAC_LOAD;
          cmd.a     = ACC_W'(dec.hr);
          cmd.b     = SECS_PER_HOUR;
          state_nxt = S_MUL_HR;
        end else begin
          cmd.op = MAC_STEP;
        end
      end
      S_MUL_HR: begin
        if (k_zero) begin
          cmd.op    = MAC_LOAD;
          cmd.a     = ACC_W'(dec.min);
          cmd.b     = SECS_PER_MIN;
          state_nxt = S_MUL_MIN;
        end else begin
          cmd.op = MAC_STEP;
        end
      end
      S_MUL_MIN: begin
        if (k_zero) begin
          cmd.op    = MAC_ADD;
          cmd.a     = ACC_W'(dec.sec);
          state_nxt = S_SECS;
        end else begin
          cmd.op = MAC_STEP;
        end
      end
      S_SECS: begin
        secs_nxt  = acc[SECS_W-1:0];
        cmd.op    = MAC_LOADC;
        cmd.a     = acc;
        cmd.b     = NANOS_PER_SEC;
        state_nxt = S_MUL_NS;
      end
      S_MUL_NS: begin
        if (k_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op = MAC_STEP;
        end
      end
      S_DONE: begin
        if (out_free) begin
          res.done  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cc_r   <= cc_nxt;
    cy_r   <= cy_nxt;
    err_r  <= err_nxt;
    secs_r <= secs_nxt;
  end

  assign idle = (state_r == S_IDLE);

endmodule

// ----- tb/sv/tb_rtc_fields_to_unix_time.sv -----
// Self-checking testbench that drives RTC snapshots into the Unix time converter.
`timescale 1ns / 1ps

module tb_rtc_fields_to_unix_time import rftu_pkg::*;;

  localparam int F_CEN = 0;
  localparam int F_YR  = 1;
  localparam int F_MON = 2;
  localparam int F_DAY = 3;
  localparam int F_HR  = 4;
  localparam int F_MIN = 5;
  localparam int F_SEC = 6;

  localparam int unsigned FIRST_YEAR = 1970;
  localparam int unsigned MONTH_START [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                               304, 334};
  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int DRAIN_LIMIT = 20000;

  typedef struct {
    bit [SECS_W-1:0] secs;
    bit [ACC_W-1:0]  nanos;
    bit              err;
  } stamp_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = REG_HOUR_24_MODE;
  logic                  cfg_wdata = 1'b0;

  int send_idle = 0;
  int stall_pct = 0;
  bit drain_lost = 1'b0;

  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned leaps_upto(int unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  class unix_time_scoreboard;
    bit hour_24 = 1'b1;
    bit binary = 1'b0;
    int failures = 0;
    stamp_t stamps_due[$];

    function int pending();
      return stamps_due.size();
    endfunction

    function stamp_t to_unix(logic [IN_DATA_W-1:0] d);
      int unsigned f [7];
      int unsigned year;
      int unsigned mlen;
      int unsigned days;
      bit pm;
      bit bad;
      bit [63:0] secs;
      stamp_t s;
      for (int i = 0; i < 7; i++) f[i] = d[8*i +: 8];
      pm = 1'b0;
      bad = 1'b0;
      if (!hour_24) begin
        pm = f[F_HR][7];
        f[F_HR] = f[F_HR] & 'h7F;
      end
      if (!binary) begin
        for (int i = 0; i < 7; i++) f[i] = (f[i] >> 4) * 10 + (f[i] & 15);
      end
      if (hour_24) begin
        if (f[F_HR] > 23) bad = 1'b1;
      end else if (f[F_HR] < 1 || f[F_HR] > 12) begin
        bad = 1'b1;
      end else if (f[F_HR] == 12) begin
        f[F_HR] = pm ? 12 : 0;
      end else if (pm) begin
        f[F_HR] = f[F_HR] + 12;
      end
      if (f[F_CEN] > 99 || f[F_YR] > 99 || f[F_MIN] > 59 || f[F_SEC] > 59) bad = 1'b1;
      year = f[F_CEN] * 100 + f[F_YR];
      if (year < FIRST_YEAR) bad = 1'b1;
      if (f[F_MON] < 1 || f[F_MON] > 12) begin
        bad = 1'b1;
      end else begin
        mlen = MONTH_DAYS[f[F_MON] - 1] + ((f[F_MON] == 2 && leap_year(year)) ? 1 : 0);
        if (f[F_DAY] < 1 || f[F_DAY] > mlen) bad = 1'b1;
      end
      s.err = bad;
      s.secs = '0;
      s.nanos = '0;
      if (!bad) begin
        days = (year - FIRST_YEAR) * 365 + leaps_upto(year - 1) - leaps_upto(FIRST_YEAR - 1)
             + MONTH_START[f[F_MON] - 1] + f[F_DAY] - 1;
        if (f[F_MON] > 2 && leap_year(year)) days = days + 1;
        secs = 64'(days) * 64'd86400 + 64'(f[F_HR]) * 64'd3600 + 64'(f[F_MIN]) * 64'd60
             + 64'(f[F_SEC]);
        s.secs = secs[SECS_W-1:0];
        s.nanos = secs * 64'd1000000000;
      end
      return s;
    endfunction

    function void note_snapshot(logic [IN_DATA_W-1:0] d);
      stamps_due.push_back(to_unix(d));
    endfunction

    function void check_stamp(logic [OUT_DATA_W-1:0] d, logic [0:0] u);
      stamp_t e;
      if (stamps_due.size() == 0) begin
        failures++;
        $error("unexpected result transaction: seconds %0d", d[SECS_W-1:0]);
        return;
      end
      e = stamps_due.pop_front();
      if (d[SECS_W-1:0] !== e.secs) begin
        failures++;
        $error("unix_seconds: expected %0d, got %0d", e.secs, d[SECS_W-1:0]);
      end
      if (d[SECS_W +: ACC_W] !== e.nanos) begin
        failures++;
        $error("unix_nanoseconds: expected %0d, got %0d", e.nanos, d[SECS_W +: ACC_W]);
      end
      if (u[0] !== e.err) begin
        failures++;
        $error("date_error: expected %0d, got %0d", e.err, u[0]);
      end
    endfunction
  endclass

  unix_time_scoreboard sb;

  rtc_fields_to_unix_time dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_snapshot(in_tdata);
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_stamp(out_tdata, out_tuser);
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack7(logic [7:0] c, logic [7:0] y, logic [7:0] mo,
                                                 logic [7:0] d, logic [7:0] h, logic [7:0] mi,
                                                 logic [7:0] s);
    return {s, mi, h, d, mo, y, c};
  endfunction

  function automatic logic [7:0] to_field(int unsigned v);
    if (sb.binary) begin
      return v[7:0];
    end
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // Most dates stay near the epoch, since the year walk steps once per year from it.
  function automatic logic [IN_DATA_W-1:0] random_date();
    int unsigned pick;
    int unsigned year;
    int unsigned mon;
    int unsigned day;
    int unsigned mlen;
    logic [7:0] hr_byte;
    logic [IN_DATA_W-1:0] d;
    pick = $urandom_range(99);
    if (pick < 15) begin
      d[31:0] = $urandom();
      d[55:32] = 24'($urandom());
      return d;
    end
    year = ($urandom_range(19) == 0) ? $urandom_range(9999, 1970) : $urandom_range(2130, 1970);
    mon = $urandom_range(12, 1);
    mlen = MONTH_DAYS[mon - 1] + ((mon == 2 && leap_year(year)) ? 1 : 0);
    day = ($urandom_range(3) == 0) ? mlen : $urandom_range(mlen, 1);
    if (sb.hour_24) begin
      hr_byte = to_field($urandom_range(23));
    end else begin
      hr_byte = to_field($urandom_range(12, 1)) | {$urandom_range(1) == 1, 7'b0};
    end
    d = pack7(to_field(year / 100), to_field(year % 100), to_field(mon), to_field(day), hr_byte,
              to_field($urandom_range(59)), to_field($urandom_range(59)));
    if (pick < 25) begin
      d[8 * $urandom_range(6) +: 8] = 8'($urandom_range(255));
    end
    return d;
  endfunction

  task automatic send_item(input logic [IN_DATA_W-1:0] d);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() != 0) drain_lost = 1'b1;
    repeat (8) @(posedge clk);
  endtask

  task automatic set_modes(input bit h24, input bit bin);
    cfg_we <= 1'b1;
    cfg_index <= REG_HOUR_24_MODE;
    cfg_wdata <= h24;
    @(posedge clk);
    cfg_index <= REG_BINARY_MODE;
    cfg_wdata <= bin;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.hour_24 = h24;
    sb.binary = bin;
    @(posedge clk);
  endtask

  initial begin
    int idle_of [4];
    int stall_of [4];
    sb = new();
    idle_of = '{0, 61, 0, 14};
    stall_of = '{0, 0, 61, 14};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_modes(1'b1, 1'b0);
    send_item(pack7('h19, 'h70, 'h01, 'h01, 'h00, 'h00, 'h00));
    send_item(pack7('h99, 'h99, 'h12, 'h31, 'h23, 'h59, 'h59));
    send_item(pack7('h19, 'h69, 'h12, 'h31, 'h23, 'h59, 'h59));
    send_item(pack7('h20, 'h00, 'h02, 'h29, 'h12, 'h34, 'h56));
    send_item(pack7('h21, 'h00, 'h02, 'h29, 'h00, 'h00, 'h00));
    send_item(pack7('h20, 'h23, 'h02, 'h29, 'h00, 'h00, 'h00));
    send_item(pack7('h20, 'h24, 'h13, 'h01, 'h00, 'h00, 'h00));
    send_item(pack7('h20, 'h24, 'h00, 'h01, 'h00, 'h00, 'h00));
    send_item(pack7('h20, 'h24, 'h04, 'h31, 'h00, 'h00, 'h00));
    send_item(pack7('h20, 'h24, 'h04, 'h00, 'h00, 'h00, 'h00));
    send_item(pack7('h20, 'h24, 'h01, 'h01, 'h24, 'h00, 'h00));
    send_item(pack7('h20, 'h24, 'h01, 'h01, 'h00, 'h60, 'h00));
    send_item(pack7('h20, 'h24, 'h01, 'h01, 'h00, 'h00, 'h60));
    send_item(pack7('h20, 'h24, 'h01, 'h01, 'h92, 'h00, 'h00));
    send_item(pack7('h20, 'h1A, 'h0C, 'h1F, 'h0F, 'h3B, 'h3B));
    send_item(pack7('hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF));
    settle();
    set_modes(1'b0, 1'b0);
    send_item(pack7('h20, 'h24, 'h06, 'h15, 'h12, 'h30, 'h00));
    send_item(pack7('h20, 'h24, 'h06, 'h15, 'h92, 'h30, 'h00));
    send_item(pack7('h20, 'h24, 'h06, 'h15, 'h81, 'h30, 'h00));
    send_item(pack7('h20, 'h24, 'h06, 'h15, 'h00, 'h30, 'h00));
    send_item(pack7('h20, 'h24, 'h06, 'h15, 'h13, 'h30, 'h00));
    settle();
    set_modes(1'b1, 1'b1);
    send_item(pack7(8'd99, 8'd99, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59));
    send_item(pack7(8'd19, 8'd70, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0));
    settle();
    set_modes(1'b0, 1'b1);
    send_item(pack7(8'd20, 8'd38, 8'd1, 8'd19, 8'h8C, 8'd14, 8'd7));
    send_item(pack7(8'd20, 8'd38, 8'd1, 8'd19, 8'h0C, 8'd14, 8'd7));
    send_item(pack7(8'd20, 8'd38, 8'd1, 8'd19, 8'h8B, 8'd14, 8'd7));
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      send_idle = idle_of[phase / 2];
      stall_pct = stall_of[phase / 2];
      set_modes(phase % 2 == 0, (phase / 4 + phase) % 2 == 1);
      for (int n = 0; n < 146; n++) send_item(random_date());
      settle();
    end

    stall_pct = 0;
    repeat (200) @(posedge clk);
    if (sb.failures == 0 && !drain_lost && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
